// ===== src/rof_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster-op rectangle fill package
// Shared sizes, codes, word types and the raster operation function.
// ----------------------------------------------------------------------------
package rof_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int DIM_W       = 9;
   localparam int COORD_W     = 8;
   localparam int PIXEL_W     = 32;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'b1;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_FILL  = 2'd2;

   localparam logic [3:0] OP_COPY = 4'd0;
   localparam logic [3:0] OP_NOT  = 4'd1;
   localparam logic [3:0] OP_EQ   = 4'd2;
   localparam logic [3:0] OP_NE   = 4'd3;
   localparam logic [3:0] OP_LT   = 4'd4;
   localparam logic [3:0] OP_LE   = 4'd5;
   localparam logic [3:0] OP_GT   = 4'd6;
   localparam logic [3:0] OP_GE   = 4'd7;
   localparam logic [3:0] OP_OR   = 4'd8;
   localparam logic [3:0] OP_NOR  = 4'd9;
   localparam logic [3:0] OP_XOR  = 4'd10;
   localparam logic [3:0] OP_XNOR = 4'd11;
   localparam logic [3:0] OP_AND  = 4'd12;
   localparam logic [3:0] OP_NAND = 4'd13;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_FILL,
      ST_DRAIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [COORD_W-1:0] x_start;
      logic [COORD_W-1:0] x_end;
      logic [COORD_W-1:0] y_start;
      logic [COORD_W-1:0] y_end;
      logic [PIXEL_W-1:0] colour;
      logic [3:0]         operation;
      logic [PIXEL_W-1:0] compare_colour;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [PIXEL_W-1:0] read_data;
   } rsp_type;

   function automatic logic [PIXEL_W-1:0] apply_op(
      input logic [PIXEL_W-1:0] d,
      input logic [PIXEL_W-1:0] col,
      input logic [3:0]         op,
      input logic [PIXEL_W-1:0] cmp
   );
      logic [PIXEL_W-1:0] r;
      case (op)
         OP_NOT:  r = ~d;
         OP_EQ:   r = (d == cmp) ? col : d;
         OP_NE:   r = (d != cmp) ? col : d;
         OP_LT:   r = (d <  cmp) ? col : d;
         OP_LE:   r = (d <= cmp) ? col : d;
         OP_GT:   r = (d >  cmp) ? col : d;
         OP_GE:   r = (d >= cmp) ? col : d;
         OP_OR:   r = d | col;
         OP_NOR:  r = ~(d | col);
         OP_XOR:  r = d ^ col;
         OP_XNOR: r = ~(d ^ col);
         OP_AND:  r = d & col;
         OP_NAND: r = ~(d & col);
         default: r = col;
      endcase
      return r;
   endfunction

endpackage

// ===== src/rof_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rof_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/raster_op_rectangle_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster-op rectangle fill
// Pixel frame store with single-pixel access and rectangle raster fill.
// ----------------------------------------------------------------------------
// Request words on req_valid / req_stall carry a mode: write pixel, read pixel
// or fill rectangle. Every request gives exactly one response word on
// rsp_valid / rsp_stall with a status bit and, for a read, the pixel value.
// The frame store is one 64K x 32 RAM with a write port and a registered read
// port; pixel (x, y) sits at x + y * width.
// Timing: a write or rejected request goes from acceptance to the response
// state and then to the output register; a read passes the read state first.
// A fill reads one pixel per cycle and writes the modified value in the cycle
// after, then drains before its response. One request is in work at a time;
// the next is taken once the previous response has been moved to the output
// register, which can still be waiting on the receiver.
// csr_write_enable with csr_index selects width (0) or height (1); values
// above 256 act as 256. Reset sets both to 256 and empties the block; the
// frame store is not cleared. A stalled response holds; the block then holds
// the following response until the output register frees.
// ----------------------------------------------------------------------------
module raster_op_rectangle_fill (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rof_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rof_pkg::rsp_type                 rsp_data,
   input  logic                             csr_write_enable,
   input  logic [rof_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rof_pkg::DIM_W-1:0]        csr_write_data
);

   localparam int AW = rof_pkg::ADDR_W;
   localparam int CW = rof_pkg::COORD_W;
   localparam int DW = rof_pkg::DIM_W;
   localparam int PW = rof_pkg::PIXEL_W;

   rof_pkg::state_type state_ff, state_in;

   logic [DW-1:0] width_ff, width_in;
   logic [DW-1:0] height_ff, height_in;
   logic [DW-1:0] w_eff, h_eff;

   logic [CW-1:0] x_ff, x_in, xs_ff, xs_in, xe_ff, xe_in, y_ff, y_in, ye_ff, ye_in;
   logic [AW-1:0] row_ff, row_in;
   logic [DW-1:0] step_ff, step_in;
   logic [PW-1:0] colour_ff, colour_in, cmp_ff, cmp_in;
   logic [3:0]    op_ff, op_in;

   logic          wb_valid_ff, wb_valid_in;
   logic [AW-1:0] wb_addr_ff, wb_addr_in;

   rof_pkg::rsp_type res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rof_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                accept, out_free, pix_ok, fill_ok, last_pix;
   logic [CW+DW-1:0]    req_row;
   logic [AW-1:0]       req_addr, fill_addr;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [PW-1:0]       ram_wdata, ram_q;

   assign w_eff = (width_ff > DW'(rof_pkg::MAX_WIDTH)) ? DW'(rof_pkg::MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff > DW'(rof_pkg::MAX_HEIGHT)) ? DW'(rof_pkg::MAX_HEIGHT) : height_ff;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign pix_ok  = (DW'(req_data.x_start) < w_eff) && (DW'(req_data.y_start) < h_eff);
   assign fill_ok = pix_ok && (DW'(req_data.x_end) < w_eff) && (DW'(req_data.y_end) < h_eff)
                    && (req_data.x_end >= req_data.x_start)
                    && (req_data.y_end >= req_data.y_start);

   assign req_row   = req_data.y_start * w_eff;
   assign req_addr  = AW'(req_row) + AW'(req_data.x_start);
   assign fill_addr = row_ff + AW'(x_ff);
   assign last_pix  = (x_ff == xe_ff) && (y_ff == ye_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rof_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.mode)
                  rof_pkg::MODE_READ: state_in = pix_ok ? rof_pkg::ST_READ : rof_pkg::ST_RESP;
                  rof_pkg::MODE_FILL: state_in = fill_ok ? rof_pkg::ST_FILL : rof_pkg::ST_RESP;
                  default:            state_in = rof_pkg::ST_RESP;
               endcase
            end
         end
         rof_pkg::ST_READ:  state_in = rof_pkg::ST_RESP;
         rof_pkg::ST_FILL:  state_in = last_pix ? rof_pkg::ST_DRAIN : rof_pkg::ST_FILL;
         rof_pkg::ST_DRAIN: state_in = rof_pkg::ST_RESP;
         rof_pkg::ST_RESP:  state_in = out_free ? rof_pkg::ST_IDLE : rof_pkg::ST_RESP;
         default:           state_in = rof_pkg::ST_IDLE;
      endcase
   end

   // outputs: handshake and RAM ports
   always_comb begin
      req_stall = (state_ff != rof_pkg::ST_IDLE);
      ram_raddr = (state_ff == rof_pkg::ST_FILL) ? fill_addr : req_addr;
      ram_we    = 1'b0;
      ram_waddr = wb_addr_ff;
      ram_wdata = rof_pkg::apply_op(ram_q, colour_ff, op_ff, cmp_ff);
      if (wb_valid_ff) begin
         ram_we = 1'b1;
      end else if (accept && (req_data.mode == rof_pkg::MODE_WRITE) && pix_ok) begin
         ram_we    = 1'b1;
         ram_waddr = req_addr;
         ram_wdata = req_data.colour;
      end
   end

   // datapath next values
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rof_pkg::CSR_WIDTH:  width_in  = csr_write_data;
            rof_pkg::CSR_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end

      x_in      = x_ff;
      xs_in     = xs_ff;
      xe_in     = xe_ff;
      y_in      = y_ff;
      ye_in     = ye_ff;
      row_in    = row_ff;
      step_in   = step_ff;
      colour_in = colour_ff;
      op_in     = op_ff;
      cmp_in    = cmp_ff;
      res_in    = res_ff;

      if (accept) begin
         x_in      = req_data.x_start;
         xs_in     = req_data.x_start;
         xe_in     = req_data.x_end;
         y_in      = req_data.y_start;
         ye_in     = req_data.y_end;
         row_in    = AW'(req_row);
         step_in   = w_eff;
         colour_in = req_data.colour;
         op_in     = req_data.operation;
         cmp_in    = req_data.compare_colour;
         res_in.read_data = '0;
         case (req_data.mode) inside
            rof_pkg::MODE_WRITE, rof_pkg::MODE_READ: res_in.status = !pix_ok;
            rof_pkg::MODE_FILL:                      res_in.status = !fill_ok;
            default:                                 res_in.status = 1'b0;
         endcase
      end else if (state_ff == rof_pkg::ST_READ) begin
         res_in.read_data = ram_q;
      end else if (state_ff == rof_pkg::ST_FILL) begin
         // advance along the row, then wrap to the next row
         if (x_ff == xe_ff) begin
            x_in   = xs_ff;
            y_in   = y_ff + 1'b1;
            row_in = row_ff + AW'(step_ff);
         end else begin
            x_in = x_ff + 1'b1;
         end
      end

      wb_valid_in = (state_ff == rof_pkg::ST_FILL);
      wb_addr_in  = fill_addr;

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if ((state_ff == rof_pkg::ST_RESP) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rof_pkg::ST_IDLE;
         width_ff     <= DW'(rof_pkg::MAX_WIDTH);
         height_ff    <= DW'(rof_pkg::MAX_HEIGHT);
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      xs_ff       <= xs_in;
      xe_ff       <= xe_in;
      y_ff        <= y_in;
      ye_ff       <= ye_in;
      row_ff      <= row_in;
      step_ff     <= step_in;
      colour_ff   <= colour_in;
      op_ff       <= op_in;
      cmp_ff      <= cmp_in;
      res_ff      <= res_in;
      wb_addr_ff  <= wb_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   rof_ram #(
      .WIDTH (PW),
      .DEPTH (rof_pkg::STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_wb_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rof_pkg::ST_FILL && wb_valid_ff) |-> (wb_addr_ff != fill_addr))
      else $error("fill write-back collides with the pixel being read");

   a_wb_from_fill: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> ($past(state_ff) == rof_pkg::ST_FILL))
      else $error("write-back without a preceding fill read");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rof_pkg::ST_IDLE && !accept) |=> (state_ff == rof_pkg::ST_IDLE))
      else $error("left idle without an accepted request word");

   a_resp_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rof_pkg::ST_RESP && rsp_valid_ff && rsp_stall)
      |=> (state_ff == rof_pkg::ST_RESP && $stable(rsp_data_ff)))
      else $error("response overwritten while the output is stalled");

endmodule
